// ===== design/rstpu_pkg.sv =====
// Package for the range-sum tree core: widths, control-word types and the
// microcode ROM that the sequencer steps through. No dependencies.

package rstpu_pkg;

  localparam int SIZE   = 1024;               // elements in the tree
  localparam int POS_W  = $clog2(SIZE);       // element position
  localparam int NODE_W = POS_W + 1;          // heap node index, 1 .. 2*SIZE-1
  localparam int IDX_W  = POS_W + 2;          // query bounds, may reach 2*SIZE
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 42;
  localparam int CFG_W  = 11;
  localparam int DEPTH  = 2 * SIZE;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Microcode step addresses.
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DISP = 3'd1,
    ST_QA   = 3'd2,
    ST_QB   = 3'd3,
    ST_OUT  = 3'd4,
    ST_LEAF = 3'd5,
    ST_UP   = 3'd6,
    ST_CLR  = 3'd7
  } step_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LEAF = 2'd1,
    WR_UP   = 2'd2,
    WR_ZERO = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    RD_NONE  = 3'd0,
    RD_SIB   = 3'd1,
    RD_UPSIB = 3'd2,
    RD_L     = 3'd3,
    RD_R     = 3'd4
  } rd_sel_e;

  typedef enum logic [2:0] {
    JC_ALWAYS   = 3'd0,
    JC_IN_ACC   = 3'd1,
    JC_IS_QUERY = 3'd2,
    JC_SKIP     = 3'd3,
    JC_UP_MORE  = 3'd4,
    JC_L_GE_R   = 3'd5,
    JC_OUT_BUSY = 3'd6,
    JC_CLR_MORE = 3'd7
  } cond_e;

  typedef struct packed {
    logic    in_rdy;
    wr_sel_e wr;
    rd_sel_e rd;
    logic    acc_en;
    logic    l_inc;
    logic    lr_halve;
    logic    out_load;
    cond_e   cond;
    step_e   tgt_t;
    step_e   tgt_f;
  } uword_t;

  typedef struct packed {
    logic in_acc;
    logic is_query;
    logic skip;
    logic up_more;
    logic l_ge_r;
    logic out_busy;
    logic clr_more;
  } stat_t;

  // Microcode ROM: one control word per step.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '{in_rdy: 1'b0, wr: WR_NONE, rd: RD_NONE, acc_en: 1'b0, l_inc: 1'b0,
          lr_halve: 1'b0, out_load: 1'b0, cond: JC_ALWAYS,
          tgt_t: ST_IDLE, tgt_f: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = JC_IN_ACC;
        w.tgt_t  = ST_DISP;
        w.tgt_f  = ST_IDLE;
      end
      ST_DISP: begin
        w.cond  = JC_IS_QUERY;
        w.tgt_t = ST_QA;
        w.tgt_f = ST_LEAF;
      end
      ST_QA: begin
        w.acc_en = 1'b1;
        w.rd     = RD_L;
        w.l_inc  = 1'b1;
        w.cond   = JC_L_GE_R;
        w.tgt_t  = ST_OUT;
        w.tgt_f  = ST_QB;
      end
      ST_QB: begin
        w.acc_en   = 1'b1;
        w.rd       = RD_R;
        w.lr_halve = 1'b1;
        w.cond     = JC_ALWAYS;
        w.tgt_t    = ST_QA;
        w.tgt_f    = ST_QA;
      end
      ST_OUT: begin
        w.out_load = 1'b1;
        w.cond     = JC_OUT_BUSY;
        w.tgt_t    = ST_OUT;
        w.tgt_f    = ST_IDLE;
      end
      ST_LEAF: begin
        w.wr    = WR_LEAF;
        w.rd    = RD_SIB;
        w.cond  = JC_SKIP;
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_UP;
      end
      ST_UP: begin
        w.wr    = WR_UP;
        w.rd    = RD_UPSIB;
        w.cond  = JC_UP_MORE;
        w.tgt_t = ST_UP;
        w.tgt_f = ST_IDLE;
      end
      ST_CLR: begin
        w.wr    = WR_ZERO;
        w.cond  = JC_CLR_MORE;
        w.tgt_t = ST_CLR;
        w.tgt_f = ST_IDLE;
      end
      default: begin
        w.cond = JC_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/rstpu_useq.sv =====
// Microcode sequencer: step counter, control-word ROM lookup and the
// conditional jump logic. Depends on rstpu_pkg.

module rstpu_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rstpu_pkg::stat_t stat_i,
  output rstpu_pkg::uword_t ctl_o
);

  rstpu_pkg::step_e upc_q, upc_d;
  logic             take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rstpu_pkg::ST_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    ctl_o = rstpu_pkg::ucode(upc_q);
    case (ctl_o.cond)
      rstpu_pkg::JC_ALWAYS:   take = 1'b1;
      rstpu_pkg::JC_IN_ACC:   take = stat_i.in_acc;
      rstpu_pkg::JC_IS_QUERY: take = stat_i.is_query;
      rstpu_pkg::JC_SKIP:     take = stat_i.skip;
      rstpu_pkg::JC_UP_MORE:  take = stat_i.up_more;
      rstpu_pkg::JC_L_GE_R:   take = stat_i.l_ge_r;
      rstpu_pkg::JC_OUT_BUSY: take = stat_i.out_busy;
      rstpu_pkg::JC_CLR_MORE: take = stat_i.clr_more;
      default:                take = 1'b1;
    endcase
    upc_d = take ? ctl_o.tgt_t : ctl_o.tgt_f;
  end

  // The clearing pass runs only once, straight out of reset.
  a_clr_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == rstpu_pkg::ST_CLR) |-> ($past(upc_q) == rstpu_pkg::ST_CLR))
    else $error("sequencer re-entered the clearing pass");

endmodule

// ===== design/rstpu_dpath.sv =====
// Datapath of the range-sum tree: operand decode, node index registers,
// accumulator, tree memory and output register. Depends on rstpu_pkg.

module rstpu_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rstpu_pkg::uword_t                    ctl_i,
  output rstpu_pkg::stat_t                     stat_o,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic        [rstpu_pkg::POS_W-1:0]   position_i,
  input  logic signed [rstpu_pkg::VAL_W-1:0]   value_i,
  input  logic        [rstpu_pkg::POS_W-1:0]   range_low_i,
  input  logic        [rstpu_pkg::POS_W-1:0]   range_high_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rstpu_pkg::SUM_W-1:0]   sum_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [rstpu_pkg::CFG_W-1:0]   cfg_size_in_use_i
);

  localparam logic [rstpu_pkg::CFG_W-1:0]  SizeCfg  = rstpu_pkg::CFG_W'(rstpu_pkg::SIZE);
  localparam logic [rstpu_pkg::NODE_W-1:0] SizeNode = rstpu_pkg::NODE_W'(rstpu_pkg::SIZE);
  localparam logic [rstpu_pkg::IDX_W-1:0]  SizeIdx  = rstpu_pkg::IDX_W'(rstpu_pkg::SIZE);

  logic [rstpu_pkg::SUM_W-1:0]  mem [rstpu_pkg::DEPTH];

  logic [rstpu_pkg::CFG_W-1:0]  size_q;
  logic [rstpu_pkg::NODE_W-1:0] clr_q;
  logic                         out_valid_q;
  logic                         pend_q, pend_d;
  logic                         op_q, skip_q;
  logic [rstpu_pkg::NODE_W-1:0] i_q;
  logic [rstpu_pkg::SUM_W-1:0]  cur_q, acc_q, sum_q, rdata_q;
  logic [rstpu_pkg::IDX_W-1:0]  l_q, r_q;

  logic                         in_acc, out_busy, out_load, mem_we;
  logic [rstpu_pkg::CFG_W-1:0]  n_eff, hi_c, lo_ext, pos_ext, hi_ext;
  logic                         empty;
  logic [rstpu_pkg::IDX_W-1:0]  l_init, r_init, r_dec;
  logic [rstpu_pkg::SUM_W-1:0]  val_ext, up_sum, acc_add, wdata;
  logic [rstpu_pkg::NODE_W-1:0] waddr, raddr, i_up;

  assign in_acc      = in_valid_i & ctl_i.in_rdy;
  assign in_ready_o  = ctl_i.in_rdy;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_q;
  assign out_busy    = out_valid_q & ~out_ready_i;
  assign out_load    = ctl_i.out_load & ~out_busy;

  // Operand decode at accept time.
  always_comb begin
    n_eff   = (size_q > SizeCfg) ? SizeCfg : size_q;
    lo_ext  = rstpu_pkg::CFG_W'(range_low_i);
    hi_ext  = rstpu_pkg::CFG_W'(range_high_i);
    pos_ext = rstpu_pkg::CFG_W'(position_i);
    hi_c    = (hi_ext > n_eff - 1'b1) ? n_eff - 1'b1 : hi_ext;
    empty   = (n_eff == '0) || (lo_ext > hi_c);
    l_init  = SizeIdx + rstpu_pkg::IDX_W'(range_low_i);
    r_init  = SizeIdx + rstpu_pkg::IDX_W'(hi_c) + 1'b1;
    val_ext = {{(rstpu_pkg::SUM_W - rstpu_pkg::VAL_W){value_i[rstpu_pkg::VAL_W-1]}}, value_i};
  end

  assign i_up    = i_q >> 1;
  assign r_dec   = r_q - 1'b1;
  assign up_sum  = cur_q + rdata_q;
  assign acc_add = acc_q + (pend_q ? rdata_q : '0);

  always_comb begin
    waddr  = i_q;
    wdata  = cur_q;
    mem_we = 1'b0;
    case (ctl_i.wr)
      rstpu_pkg::WR_LEAF: begin
        mem_we = ~skip_q;
      end
      rstpu_pkg::WR_UP: begin
        waddr  = i_up;
        wdata  = up_sum;
        mem_we = 1'b1;
      end
      rstpu_pkg::WR_ZERO: begin
        waddr  = clr_q;
        wdata  = '0;
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    raddr  = '0;
    pend_d = 1'b0;
    case (ctl_i.rd)
      rstpu_pkg::RD_SIB:   raddr = i_q ^ rstpu_pkg::NODE_W'(1);
      rstpu_pkg::RD_UPSIB: raddr = i_up ^ rstpu_pkg::NODE_W'(1);
      rstpu_pkg::RD_L: begin
        raddr  = l_q[rstpu_pkg::NODE_W-1:0];
        pend_d = l_q[0];
      end
      rstpu_pkg::RD_R: begin
        raddr  = r_dec[rstpu_pkg::NODE_W-1:0];
        pend_d = r_q[0];
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeCfg;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_size_in_use_i;
      end
      if (ctl_i.wr == rstpu_pkg::WR_ZERO) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      skip_q <= (pos_ext >= n_eff);
      i_q    <= SizeNode + rstpu_pkg::NODE_W'(position_i);
      cur_q  <= val_ext;
      l_q    <= empty ? '0 : l_init;
      r_q    <= empty ? '0 : r_init;
      acc_q  <= '0;
    end else begin
      if (ctl_i.wr == rstpu_pkg::WR_UP) begin
        cur_q <= up_sum;
        i_q   <= i_up;
      end
      if (ctl_i.acc_en) begin
        acc_q <= acc_add;
      end
      if (ctl_i.l_inc) begin
        l_q <= l_q + rstpu_pkg::IDX_W'(l_q[0]);
      end
      if (ctl_i.lr_halve) begin
        l_q <= l_q >> 1;
        r_q <= (r_q - rstpu_pkg::IDX_W'(r_q[0])) >> 1;
      end
    end
    if (out_load) begin
      sum_q <= acc_q;
    end
  end

  always_comb begin
    stat_o.in_acc   = in_acc;
    stat_o.is_query = (op_q == rstpu_pkg::OP_QUERY);
    stat_o.skip     = skip_q;
    stat_o.up_more  = (i_q[rstpu_pkg::NODE_W-1:2] != '0);
    stat_o.l_ge_r   = (l_q >= r_q);
    stat_o.out_busy = out_busy;
    stat_o.clr_more = (clr_q != '1);
  end

  // Items are only taken once the clearing sweep has wrapped its counter.
  a_rdy_after_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.in_rdy |-> (clr_q == '0))
    else $error("item accepted before the tree was cleared");

  // The upward walk never writes above the root.
  a_up_in_tree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.wr == rstpu_pkg::WR_UP) |-> (i_q >= rstpu_pkg::NODE_W'(2)))
    else $error("path update ran past the root");

  // A pending accumulate always comes from a query bound read.
  a_pend_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(ctl_i.rd) == rstpu_pkg::RD_L || $past(ctl_i.rd) == rstpu_pkg::RD_R))
    else $error("accumulate without a query read");

endmodule

// ===== design/range_sum_tree_point_update_core.sv =====
// Top level of the range-sum tree with point update: a microcoded sequencer
// driving a datapath with a 2048-entry partial-sum memory.
// Depends on rstpu_pkg, rstpu_useq and rstpu_dpath.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   op_i, position_i, value_i,
//                                                range_low_i, range_high_i
//  out      output     out_valid_o / out_ready_i sum_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_size_in_use_i
//
// A set steps through accept, dispatch, then one step per tree level from
// the leaf to the root, each writing one node while reading its sibling on
// the same memory cycle; a set past the size in use ends at the leaf step
// without writing. A query reads its low and high bounds on alternate steps,
// one pair per level visited, as the single read port serves both. After
// reset the memory is swept to zero, one node per cycle over all 2048 nodes;
// in_ready_o stays low during the sweep while configuration writes are taken.
// A finished sum waits in the output register, and the core goes on accepting
// input; a later query holds in its last step until that register is free.

module range_sum_tree_point_update_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic        [rstpu_pkg::POS_W-1:0]  position_i,
  input  logic signed [rstpu_pkg::VAL_W-1:0]  value_i,
  input  logic        [rstpu_pkg::POS_W-1:0]  range_low_i,
  input  logic        [rstpu_pkg::POS_W-1:0]  range_high_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rstpu_pkg::SUM_W-1:0]  sum_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [rstpu_pkg::CFG_W-1:0]  cfg_size_in_use_i
);

  // Control word from the microcode ROM and status flags back from the
  // datapath, which the sequencer uses for its conditional jumps.
  rstpu_pkg::uword_t ctl;
  rstpu_pkg::stat_t  stat;

  rstpu_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // The datapath holds the tree memory, the bound and path index registers,
  // the accumulator, the size register and the output register.
  rstpu_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .stat_o            (stat),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .position_i        (position_i),
    .value_i           (value_i),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sum_o             (sum_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_size_in_use_i (cfg_size_in_use_i)
  );

endmodule

// ===== verif/range_sum_checker.sv =====
// Scoreboard for the range-sum tree core: watches the input, output and
// configuration channels, predicts every query sum and compares it.
// Depends on rstpu_pkg for widths and operation codes.

module range_sum_checker
  import rstpu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    op_i,
  input  logic        [POS_W-1:0] position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic        [POS_W-1:0] range_low_i,
  input  logic        [POS_W-1:0] range_high_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic        [CFG_W-1:0] cfg_size_i,
  output int                      errors_o,
  output int                      pending_o
);

  // Flat copy of the array; a range sum is simply added up element by element.
  logic signed [VAL_W-1:0] element_vals [SIZE];
  logic        [CFG_W-1:0] size_in_use;
  logic        [SUM_W-1:0] sum_expect_q [$];
  logic        [SUM_W-1:0] expected_sum;

  function automatic int unsigned active_len();
    return (size_in_use > SIZE) ? SIZE : size_in_use;
  endfunction

  function automatic logic [SUM_W-1:0] range_total(int unsigned lo, int unsigned hi);
    int unsigned     n;
    logic [SUM_W-1:0] acc;
    n   = active_len();
    acc = '0;
    if (n == 0) return '0;
    if (hi > n - 1) hi = n - 1;
    // An empty range leaves the loop untouched and the sum at zero.
    for (int unsigned k = lo; k <= hi; k++) begin
      acc += {{(SUM_W-VAL_W){element_vals[k][VAL_W-1]}}, element_vals[k]};
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SIZE; k++) element_vals[k] = '0;
      size_in_use = CFG_W'(SIZE);
      sum_expect_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // Results are retired before new queries are queued, so a result can
      // never be matched against a query accepted on the same edge.
      if (out_valid_i && out_ready_i) begin
        if (sum_expect_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("[%0t] unexpected result: sum %0d", $realtime, sum_i);
        end else begin
          expected_sum = sum_expect_q.pop_front();
          if (sum_i !== expected_sum) begin
            errors_o++;
            if (errors_o <= 10)
              $display("[%0t] sum mismatch: expected %0d, got %0d", $realtime,
                       $signed(expected_sum), sum_i);
          end
        end
      end

      // A transaction taken on the same edge as a size write still sees the
      // old size, so the size is updated after the input is handled.
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_SET) begin
          if (position_i < active_len()) element_vals[position_i] = value_i;
        end else begin
          sum_expect_q.insert(sum_expect_q.size(),
                              range_total(32'(range_low_i), 32'(range_high_i)));
        end
      end

      if (cfg_valid_i && cfg_ready_i) size_in_use = cfg_size_i;

      pending_o = sum_expect_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the range-sum tree testbench: clock, reset, stimulus and verdict.
// Depends on rstpu_pkg, range_sum_tree_point_update_core and range_sum_checker.

module tb;
  import rstpu_pkg::*;

  // The slowest correct run stays well inside this limit: about 1700
  // transactions, the clearing sweep after reset, one long output hold-off
  // and a settling pause per phase.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 800;
  // A set produces no result and walks 10 tree levels, so this pause is
  // enough to let the last one finish before the register moves.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 10;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_op;
  logic        [POS_W-1:0] in_pos;
  logic signed [VAL_W-1:0] in_value;
  logic        [POS_W-1:0] in_lo;
  logic        [POS_W-1:0] in_hi;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [SUM_W-1:0] out_sum;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic        [CFG_W-1:0] cfg_size;

  int          errors;
  int          pending;
  int          cycle_count;
  int          burst_left;
  int          hold_requests;
  int          hold_served;
  int unsigned cur_size;

  range_sum_tree_point_update_core i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .op_i              (in_op),
    .position_i        (in_pos),
    .value_i           (in_value),
    .range_low_i       (in_lo),
    .range_high_i      (in_hi),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .sum_o             (out_sum),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_size_in_use_i (cfg_size)
  );

  range_sum_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (in_op),
    .position_i   (in_pos),
    .value_i      (in_value),
    .range_low_i  (in_lo),
    .range_high_i (in_hi),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sum_i        (out_sum),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_size_i   (cfg_size),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hang, a lost result or a stuck handshake all end up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** range_sum_tree_point_update_core: FAILED **");
      $finish;
    end
  end

  // Receiver. It decides at the rising edge and drives at the falling edge.
  // Its stall pattern switches at random among four modes: always ready,
  // coin flip, mostly stalled, or ready on a regular beat. When the
  // stimulus asks for it, it holds off for a long stretch so that a finished
  // sum sits in the output register and the next query backs up the input.
  initial begin : receiver
    int   hold_left;
    int   mode_left;
    int   rx_mode;
    int   tick;
    logic next_ready;
    hold_left   = 0;
    mode_left   = 0;
    rx_mode     = 0;
    tick        = 0;
    next_ready  = 1'b0;
    out_ready   = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (rx_mode)
          0:       next_ready = 1'b1;
          1:       next_ready = 1'($urandom_range(0, 1));
          2:       next_ready = ($urandom_range(0, 3) == 0);
          default: next_ready = (tick % 3 == 0);
        endcase
      end
      @(negedge clk);
      out_ready = next_ready;
    end
  end

  // Offers one transaction and returns at the falling edge after it was
  // taken. The sender works in bursts; between bursts valid drops for a
  // random gap, which is sometimes zero so that long unbroken runs occur.
  task automatic push_item(logic op_v, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 32);
    end
    in_valid = 1'b1;
    in_op    = op_v;
    in_pos   = pos;
    in_value = val;
    in_lo    = lo;
    in_hi    = hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Sets carry random range bounds and queries carry a random position and
  // value, since the core must ignore the fields that the operation leaves unused.
  task automatic set_elem(int unsigned pos, logic [VAL_W-1:0] val);
    push_item(OP_SET, POS_W'(pos), val, POS_W'($urandom()), POS_W'($urandom()));
  endtask

  task automatic query_range(int unsigned lo, int unsigned hi);
    push_item(OP_QUERY, POS_W'($urandom()), $urandom(), POS_W'(lo), POS_W'(hi));
  endtask

  // The size register moves only when the core is idle: every expected sum
  // has come back and the last set has had time to finish its path walk.
  task automatic resize(int unsigned new_size);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_size  = CFG_W'(new_size);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_size  = new_size;
  endtask

  // One random transaction. Positions and bounds lean toward the part of the
  // array in use, with some spread over the whole field. A lean of 1 or 2
  // pushes half of the set values to the largest or smallest element so that
  // sums grow toward the ends of their range.
  task automatic random_item(int lean);
    int unsigned      n;
    int unsigned      last;
    int unsigned      a;
    int unsigned      b;
    int unsigned      lo_v;
    int unsigned      hi_v;
    logic [VAL_W-1:0] v;
    n    = (cur_size > SIZE) ? SIZE : cur_size;
    last = (n > 0) ? n - 1 : 0;
    a    = $urandom_range(0, last);
    b    = $urandom_range(0, last);
    if (lean == 1 && $urandom_range(0, 1)) begin
      v = 32'h7FFF_FFFF;
    end else if (lean == 2 && $urandom_range(0, 1)) begin
      v = 32'h8000_0000;
    end else begin
      case ($urandom_range(0, 7))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = $urandom_range(0, 15) - 8;
        default: v = $urandom();
      endcase
    end
    if ($urandom_range(0, 1)) begin
      set_elem(($urandom_range(0, 7) == 0) ? $urandom() : a, v);
    end else begin
      lo_v = (a < b) ? a : b;
      hi_v = (a < b) ? b : a;
      case ($urandom_range(0, 5))
        0: begin
          lo_v = $urandom_range(0, SIZE - 1);
          hi_v = $urandom_range(0, SIZE - 1);
        end
        1: begin
          lo_v = 0;
          hi_v = SIZE - 1;
        end
        2: hi_v = lo_v;
        3: begin
          // Swapped bounds: empty unless the two happen to coincide.
          lo_v = (a < b) ? b : a;
          hi_v = (a < b) ? a : b;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) hi_v = $urandom_range(hi_v, SIZE - 1);
        end
      endcase
      query_range(lo_v, hi_v);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_size [PHASES];
    int          phase_lean [PHASES];
    phase_size = '{1024, 37, 2047, 1, 1023, 0, 0, 2, 1024, 1024};
    phase_lean = '{0,    0,  1,    0, 2,    0, 0, 0, 1,    2};
    // One phase runs at a size drawn at random.
    phase_size[6] = $urandom_range(3, SIZE);

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_SET;
    in_pos        = '0;
    in_value      = '0;
    in_lo         = '0;
    in_hi         = '0;
    cfg_valid     = 1'b0;
    cfg_size      = '0;
    cycle_count   = 0;
    burst_left    = 0;
    hold_requests = 0;
    cur_size      = SIZE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The core sweeps its memory after reset; the size write is taken during
    // the sweep and the first transaction waits for it to finish.
    resize(SIZE);

    // Directed part: the largest and smallest elements at both ends of the
    // array, the full range, single elements, swapped bounds, an element never
    // written, and an overwrite.
    set_elem(0, 32'h7FFF_FFFF);
    set_elem(SIZE - 1, 32'h8000_0000);
    set_elem(512, 32'hFFFF_FFFF);
    set_elem(1, 32'h7FFF_FFFF);
    set_elem(SIZE - 2, 32'h8000_0000);
    query_range(0, SIZE - 1);
    query_range(0, 0);
    query_range(SIZE - 1, SIZE - 1);
    query_range(1, SIZE - 2);
    query_range(600, 5);
    query_range(513, 513);
    set_elem(SIZE - 1, 0);
    query_range(0, SIZE - 1);

    // Shrunk size: a set past the end is dropped, a high bound past the end
    // is clamped, and a low bound past the end gives an empty range.
    resize(100);
    set_elem(100, 12345);
    set_elem(99, -7);
    query_range(0, SIZE - 1);
    query_range(99, SIZE - 1);
    query_range(200, SIZE - 1);

    // Size zero: nothing is written and every query sums to zero.
    resize(0);
    set_elem(0, 1);
    query_range(0, SIZE - 1);

    // All ones in the register acts as the full array.
    resize(2047);
    set_elem(SIZE - 1, 77);
    query_range(SIZE - 1, SIZE - 1);

    // Growing back: elements beyond the old size kept their values.
    resize(1);
    set_elem(1, 9);
    query_range(0, SIZE - 1);
    resize(SIZE);
    query_range(0, SIZE - 1);

    // Random part, one size per phase. The first phase starts with the long
    // receiver hold-off while the sender keeps offering transactions.
    for (int p = 0; p < PHASES; p++) begin
      resize(phase_size[p]);
      if (p == 0) hold_requests++;
      repeat ((phase_size[p] == 0) ? 30 : 180) random_item(phase_lean[p]);
    end

    // Drain: wait for every sum, then let the last set finish.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("** range_sum_tree_point_update_core: PASSED **");
    end else begin
      $display("** range_sum_tree_point_update_core: FAILED **");
    end
    $finish;
  end

endmodule
